@@ sv/hwm_pkg.sv @@
package hwm_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PointW = 8;
  localparam int unsigned RegIdxW = 2;

  localparam logic [TimeW-1:0] FreezeTimeoutReset = 32'd35000;
  localparam logic [TimeW-1:0] WarnThresholdReset = 32'd15000;
  localparam logic [TimeW-1:0] WarnIntervalReset  = 32'd5000;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_BEAT   = 2'd1,
    CMD_TRACE  = 2'd2,
    CMD_REPORT = 2'd3
  } hwm_cmd_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_ENABLE    = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_INTERVAL  = 2'd3
  } hwm_reg_e;

  typedef struct packed {
    hwm_cmd_e           cmd;
    logic [TimeW-1:0]   now_ms;
    logic [PointW-1:0]  checkpoint;
  } hwm_in_t;

  typedef struct packed {
    logic               warn;
    logic               restart;
    logic [TimeW-1:0]   elapsed_ms;
    logic               crash_valid;
    logic [TimeW-1:0]   crash_time;
    logic [TimeW-1:0]   crash_last_beat;
    logic [TimeW-1:0]   crash_elapsed;
    logic [PointW-1:0]  trace_point;
    logic [TimeW-1:0]   trace_time;
  } hwm_out_t;

  typedef struct packed {
    logic               enable;
    logic [TimeW-1:0]   timeout;
    logic [TimeW-1:0]   threshold;
    logic [TimeW-1:0]   interval;
  } hwm_cfg_t;

endpackage

@@ sv/hwm_cfg.sv @@
module hwm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hwm_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [hwm_pkg::TimeW-1:0]    cfg_wdata_i,
  output hwm_pkg::hwm_cfg_t            cfg_o
);
  import hwm_pkg::*;

  hwm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:    cfg_d.enable    = cfg_wdata_i[0];
        REG_TIMEOUT:   cfg_d.timeout   = cfg_wdata_i;
        REG_THRESHOLD: cfg_d.threshold = cfg_wdata_i;
        REG_INTERVAL:  cfg_d.interval  = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b1;
      cfg_q.timeout   <= FreezeTimeoutReset;
      cfg_q.threshold <= WarnThresholdReset;
      cfg_q.interval  <= WarnIntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/hwm_core.sv @@
module hwm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  hwm_pkg::hwm_in_t   item_i,
  input  hwm_pkg::hwm_cfg_t  cfg_i,
  output hwm_pkg::hwm_out_t  res_o
);
  import hwm_pkg::*;

  logic [TimeW-1:0]  last_beat_q, last_beat_d;
  logic [TimeW-1:0]  last_warn_q, last_warn_d;
  logic              rec_valid_q, rec_valid_d;
  logic [TimeW-1:0]  rec_time_q, rec_time_d;
  logic [TimeW-1:0]  rec_beat_q, rec_beat_d;
  logic [TimeW-1:0]  rec_elapsed_q, rec_elapsed_d;
  logic [PointW-1:0] trace_point_q, trace_point_d;
  logic [TimeW-1:0]  trace_time_q, trace_time_d;

  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  since_warn;
  logic              freeze;
  logic              warn;

  assign elapsed    = item_i.now_ms - last_beat_q;
  assign since_warn = item_i.now_ms - last_warn_q;
  assign freeze     = cfg_i.enable && (elapsed > cfg_i.timeout);
  // A freeze takes precedence; it never raises a warning on the same check.
  assign warn       = cfg_i.enable && !freeze && (elapsed > cfg_i.threshold) &&
                      (since_warn > cfg_i.interval);

  always_comb begin
    res_o         = '0;
    last_beat_d   = last_beat_q;
    last_warn_d   = last_warn_q;
    rec_valid_d   = rec_valid_q;
    rec_time_d    = rec_time_q;
    rec_beat_d    = rec_beat_q;
    rec_elapsed_d = rec_elapsed_q;
    trace_point_d = trace_point_q;
    trace_time_d  = trace_time_q;
    unique case (item_i.cmd)
      CMD_CHECK: begin
        res_o.elapsed_ms = elapsed;
        res_o.restart    = freeze;
        res_o.warn       = warn;
        if (freeze) begin
          rec_valid_d   = 1'b1;
          rec_time_d    = item_i.now_ms;
          rec_beat_d    = last_beat_q;
          rec_elapsed_d = elapsed;
          last_beat_d   = item_i.now_ms;
        end
        if (warn) begin
          last_warn_d = item_i.now_ms;
        end
      end
      CMD_BEAT: begin
        last_beat_d = item_i.now_ms;
      end
      CMD_TRACE: begin
        trace_point_d = item_i.checkpoint;
        trace_time_d  = item_i.now_ms;
      end
      CMD_REPORT: begin
        if (rec_valid_q) begin
          res_o.crash_valid     = 1'b1;
          res_o.crash_time      = rec_time_q;
          res_o.crash_last_beat = rec_beat_q;
          res_o.crash_elapsed   = rec_elapsed_q;
        end
        res_o.trace_point = trace_point_q;
        res_o.trace_time  = trace_time_q;
        rec_valid_d       = 1'b0;
      end
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_beat_q   <= '0;
      last_warn_q   <= '0;
      rec_valid_q   <= 1'b0;
      rec_time_q    <= '0;
      rec_beat_q    <= '0;
      rec_elapsed_q <= '0;
      trace_point_q <= '0;
      trace_time_q  <= '0;
    end else if (fire_i) begin
      last_beat_q   <= last_beat_d;
      last_warn_q   <= last_warn_d;
      rec_valid_q   <= rec_valid_d;
      rec_time_q    <= rec_time_d;
      rec_beat_q    <= rec_beat_d;
      rec_elapsed_q <= rec_elapsed_d;
      trace_point_q <= trace_point_d;
      trace_time_q  <= trace_time_d;
    end
  end

`ifndef SYNTH
  a_restart_sets_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.restart |=> rec_valid_q && (last_beat_q == rec_time_q))
    else $error("freeze did not capture a record and re-arm the beat");

  a_report_clears_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.cmd == CMD_REPORT) |=> !rec_valid_q)
    else $error("report did not clear the crash record");

  a_warn_updates_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.warn |=> (last_warn_q == $past(item_i.now_ms)))
    else $error("warning did not record its time");

  a_warn_excludes_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.warn && res_o.restart))
    else $error("warn and restart raised together");
`endif

endmodule

@@ sv/heartbeat_watchdog_monitor.sv @@
// Heartbeat watchdog monitor: each transfer carries a command (check, heartbeat, trace or
// report) with a millisecond timestamp, and yields exactly one result transfer. The block
// takes one item every cycle while the output is not stalled. Each item passes through the
// input register and then the output register, with the evaluation (two 32-bit
// subtractions and three compares) between them. Back pressure on the output stalls
// the input register, which then holds the input ready low. Configuration writes take
// effect at the next clock and should only be issued while no item is in flight.
module heartbeat_watchdog_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hwm_pkg::hwm_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hwm_pkg::hwm_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [hwm_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [hwm_pkg::TimeW-1:0]    cfg_wdata_i
);
  import hwm_pkg::*;

  hwm_cfg_t cfg;
  hwm_in_t  in_data_q;
  logic     in_valid_q, in_valid_d;
  hwm_out_t out_data_q, res;
  logic     out_valid_q, out_valid_d;
  logic     advance;
  logic     in_xfer;

  hwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hwm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // The held item moves on when the output register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_stalled_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("held item lost while stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("unread result overwritten");

  a_accept_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input not ready while the input register is empty");
`endif

endmodule

@@ sim/heartbeat_watchdog_monitor_tb.sv @@
`timescale 1ns / 100ps

module heartbeat_watchdog_monitor_tb;

  import hwm_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  hwm_in_t             in_data;
  logic                out_valid;
  logic                out_ready;
  hwm_out_t            out_data;
  logic                cfg_we;
  logic [RegIdxW-1:0]  cfg_idx;
  logic [TimeW-1:0]    cfg_wdata;

  // Watchdog state as the testbench expects it to be.
  hwm_cfg_t            wd_cfg = '{enable: 1'b1, timeout: FreezeTimeoutReset,
                                  threshold: WarnThresholdReset, interval: WarnIntervalReset};
  logic [TimeW-1:0]    beat_time = '0;
  logic [TimeW-1:0]    warn_time = '0;
  logic                rec_valid = 1'b0;
  logic [TimeW-1:0]    rec_time = '0;
  logic [TimeW-1:0]    rec_beat = '0;
  logic [TimeW-1:0]    rec_elapsed = '0;
  logic [PointW-1:0]   trace_pt = '0;
  logic [TimeW-1:0]    trace_at = '0;

  hwm_out_t            pending_results[$];
  int                  mismatch_count = 0;
  int                  sender_idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_ticket = 0;
  logic [TimeW-1:0]    clock_ms = '0;

  heartbeat_watchdog_monitor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hwm_out_t predict_watchdog(input hwm_in_t item);
    hwm_out_t         res;
    logic [TimeW-1:0] since_beat;
    logic [TimeW-1:0] since_warn;
    res = '0;
    case (item.cmd)
      CMD_CHECK: begin
        since_beat = item.now_ms - beat_time;
        since_warn = item.now_ms - warn_time;
        res.elapsed_ms = since_beat;
        if (wd_cfg.enable) begin
          // A freeze takes precedence and leaves the warning timer alone.
          if (since_beat > wd_cfg.timeout) begin
            rec_valid   = 1'b1;
            rec_time    = item.now_ms;
            rec_beat    = beat_time;
            rec_elapsed = since_beat;
            beat_time   = item.now_ms;
            res.restart = 1'b1;
          end else if (since_beat > wd_cfg.threshold && since_warn > wd_cfg.interval) begin
            warn_time = item.now_ms;
            res.warn  = 1'b1;
          end
        end
      end
      CMD_BEAT: begin
        beat_time = item.now_ms;
      end
      CMD_TRACE: begin
        trace_pt = item.checkpoint;
        trace_at = item.now_ms;
      end
      default: begin
        if (rec_valid) begin
          res.crash_valid     = 1'b1;
          res.crash_time      = rec_time;
          res.crash_last_beat = rec_beat;
          res.crash_elapsed   = rec_elapsed;
        end
        res.trace_point = trace_pt;
        res.trace_time  = trace_at;
        rec_valid = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Entered and left right after a rising edge; valid stays high between items unless an idle gap is drawn.
  task automatic send_item(input hwm_cmd_e cmd, input logic [TimeW-1:0] now,
                           input logic [PointW-1:0] point);
    hwm_in_t item;
    item.cmd        = cmd;
    item.now_ms     = now;
    item.checkpoint = point;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_watchdog(item));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input hwm_reg_e idx, input logic [TimeW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:    wd_cfg.enable    = val[0];
      REG_TIMEOUT:   wd_cfg.timeout   = val;
      REG_THRESHOLD: wd_cfg.threshold = val;
      default:       wd_cfg.interval  = val;
    endcase
  endtask

  function automatic logic [TimeW-1:0] pick_limit(input int unsigned hi);
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind == 0) return '0;
    if (kind == 1) return '1;
    return $urandom_range(hi);
  endfunction

  task automatic randomize_config();
    logic [TimeW-1:0] en_word;
    en_word    = $urandom();
    en_word[0] = ($urandom_range(9) != 0);
    write_reg(REG_ENABLE, en_word);
    write_reg(REG_TIMEOUT, pick_limit(3000));
    write_reg(REG_THRESHOLD, pick_limit(2000));
    write_reg(REG_INTERVAL, pick_limit(800));
  endtask

  // Mostly a clock that moves forward in plausible steps, with some raw noise.
  function automatic hwm_in_t next_random_item();
    hwm_in_t     item;
    int unsigned r;
    int unsigned span;
    item.checkpoint = PointW'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 8) begin
      item.cmd    = hwm_cmd_e'(2'($urandom_range(3)));
      item.now_ms = $urandom();
      return item;
    end
    span = (wd_cfg.timeout == 0 || wd_cfg.timeout > 3000) ? 3000 : wd_cfg.timeout;
    r = $urandom_range(99);
    if (r < 60) clock_ms += $urandom_range(span / 3);
    else if (r < 92) clock_ms += $urandom_range(2 * span);
    else clock_ms += $urandom();
    r = $urandom_range(99);
    item.cmd = (r < 50) ? CMD_CHECK : (r < 70) ? CMD_BEAT : (r < 85) ? CMD_TRACE : CMD_REPORT;
    item.now_ms = clock_ms;
    return item;
  endfunction

  task automatic test_reset_defaults();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_item(CMD_REPORT, 32'd0, 8'h00);
    send_item(CMD_CHECK, 32'd0, 8'h00);
    send_item(CMD_CHECK, 32'd15001, 8'h00);
    send_item(CMD_CHECK, 32'd15002, 8'h00);
    send_item(CMD_CHECK, 32'd20002, 8'h00);
    // Exactly at the timeout is not yet a freeze.
    send_item(CMD_CHECK, 32'd35000, 8'h00);
    send_item(CMD_CHECK, 32'd35001, 8'h3C);
    send_item(CMD_REPORT, 32'd35002, 8'h00);
    send_item(CMD_REPORT, 32'd35003, 8'h00);
    send_item(CMD_TRACE, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_REPORT, 32'd1, 8'h00);
    send_item(CMD_TRACE, 32'd0, 8'h00);
    // Heartbeat just before the wrap; the check after the wrap sees a small gap.
    send_item(CMD_BEAT, 32'hFFFF_FFF0, 8'hA5);
    send_item(CMD_CHECK, 32'h0000_0010, 8'h5A);
    send_item(CMD_CHECK, 32'hFFFF_FFEF, 8'h00);
    send_item(CMD_BEAT, 32'd0, 8'h00);
    // A second freeze overwrites the record that was never reported.
    send_item(CMD_CHECK, 32'd40000, 8'h00);
    send_item(CMD_REPORT, 32'd40001, 8'h00);
    end_burst();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    send_item(CMD_CHECK, 32'h8000_0000, 8'h00);
    send_item(CMD_REPORT, 32'h8000_0001, 8'h00);
    end_burst();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_INTERVAL, 32'd0);
    send_item(CMD_BEAT, 32'd100, 8'h00);
    send_item(CMD_CHECK, 32'd100, 8'h00);
    send_item(CMD_CHECK, 32'd101, 8'h00);
    end_burst();
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_CHECK, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_CHECK, 32'hFFFF_FFFF, 8'h00);
    end_burst();
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 32'd50, 8'h00);
    send_item(CMD_REPORT, 32'd51, 8'h00);
    end_burst();
    write_reg(REG_TIMEOUT, FreezeTimeoutReset);
    write_reg(REG_THRESHOLD, WarnThresholdReset);
    write_reg(REG_INTERVAL, WarnIntervalReset);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle, input int stall);
    hwm_in_t item;
    sender_idle_pct = idle;
    stall_pct = stall;
    randomize_config();
    clock_ms = $urandom();
    repeat (n_items) begin
      item = next_random_item();
      send_item(item.cmd, item.now_ms, item.checkpoint);
    end
    end_burst();
  endtask

  // The receiver holds off long enough for the block to fill and push back.
  task automatic test_output_stall();
    hwm_in_t item;
    sender_idle_pct = 0;
    stall_pct = 0;
    randomize_config();
    hold_ticket++;
    repeat (80) begin
      item = next_random_item();
      send_item(item.cmd, item.now_ms, item.checkpoint);
    end
    end_burst();
  endtask

  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic check_field(input string what, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    hwm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transfer with none expected, expected nothing, actual %h",
                 $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("warn", TimeW'(want.warn), TimeW'(out_data.warn));
        check_field("restart", TimeW'(want.restart), TimeW'(out_data.restart));
        check_field("elapsed_ms", want.elapsed_ms, out_data.elapsed_ms);
        check_field("crash_valid", TimeW'(want.crash_valid), TimeW'(out_data.crash_valid));
        check_field("crash_time", want.crash_time, out_data.crash_time);
        check_field("crash_last_beat", want.crash_last_beat, out_data.crash_last_beat);
        check_field("crash_elapsed", want.crash_elapsed, out_data.crash_elapsed);
        check_field("trace_point", TimeW'(want.trace_point), TimeW'(out_data.trace_point));
        check_field("trace_time", want.trace_time, out_data.trace_time);
      end
    end
  end

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_random_traffic(320, 0, 0);
    test_random_traffic(320, 66, 0);
    test_random_traffic(320, 0, 66);
    test_random_traffic(320, 19, 19);
    test_output_stall();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[heartbeat_watchdog_monitor] OK");
    end else begin
      $display("[heartbeat_watchdog_monitor] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[heartbeat_watchdog_monitor] ERROR");
    $finish;
  end

endmodule

@@ heartbeat_watchdog_monitor.f @@
sv/hwm_pkg.sv
sv/hwm_cfg.sv
sv/hwm_core.sv
sv/heartbeat_watchdog_monitor.sv
sim/heartbeat_watchdog_monitor_tb.sv
